### rtl/tgdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgdc_pkg
// Shared sizes, operation codes and helpers of the tile grid disc carver.
// ----------------------------------------------------------------------------
package tgdc_pkg;

  // grid store geometry
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_RADIUS = 63;
  localparam int DEPTH      = MAX_COLS * MAX_ROWS;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 14;
  localparam int CFG_W   = 7;
  localparam int DATA_W  = 8;
  localparam int IDX_W   = 8;   // clamped index, up to 255
  localparam int LIM_W   = 9;   // grid limit, up to 256

  // walk arithmetic
  localparam int PIX_W  = COORD_W + 1;        // centre minus radius, signed
  localparam int TILE_W = COORD_W - 1;        // non-negative start pixel
  localparam int TX_W   = COORD_W;            // tile coordinate while stepping
  localparam int DX_W   = RAD_W + 2;          // signed offset
  localparam int R2_W   = 2 * RAD_W;          // radius squared
  localparam int D2_W   = 2 * RAD_W + 2;      // signed squared distance
  localparam int CNT_W  = $clog2(TILE_W);

  // operation codes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_CARVE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TILE_SIZE   = 2'd0;
  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd2;

  localparam logic [CFG_W-1:0] TILE_SIZE_RST   = 7'd10;
  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd50;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd30;

  // number of tiles in use along one side
  function automatic logic [LIM_W-1:0] used_dim(input logic [CFG_W-1:0] g,
                                                 input logic [LIM_W-1:0] maxv);
    logic [LIM_W-1:0] gx;
    gx = LIM_W'(g);
    if (g == '0) begin
      return LIM_W'(1);
    end else if (gx > maxv) begin
      return maxv;
    end
    return gx;
  endfunction

  // clamp a signed coordinate into [0, limit-1]
  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [PIX_W-1:0] v,
                                                  input logic [LIM_W-1:0] limit);
    logic [LIM_W-1:0] top;
    top = limit - LIM_W'(1);
    if (v < 0) begin
      return '0;
    end else if (v >= $signed({{(PIX_W-LIM_W){1'b0}}, limit})) begin
      return top[IDX_W-1:0];
    end
    return v[IDX_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] tile_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
  endfunction

endpackage
`default_nettype wire

### rtl/tile_grid_disc_carver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_grid_disc_carver
// Byte tile grid with read, write and filled disc carve operations.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   operation, coord_x/y, radius, fill
//  out      output     out_valid_o / out_stall_i tile_value, finished_op
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  read and write go from idle to the final state and back to idle.
//  carve runs a bit-serial divider that finds the starting tile column and
//  row, then one stepper visits one pixel per cycle over the bounding square
//  and writes the single store port when in the disc. the result register
//  loads in the final state; an ignored operation is dropped with no
//  result. a stalled result holds the next operation in the final state,
//  with input stalled, until it leaves. reset clears control, not the tile store.
//
module tile_grid_disc_carver (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [tgdc_pkg::OP_W-1:0]        operation_i,
  input  wire logic signed [tgdc_pkg::COORD_W-1:0] coord_x_i,
  input  wire logic signed [tgdc_pkg::COORD_W-1:0] coord_y_i,
  input  wire logic [5:0]                       radius_i,
  input  wire logic [tgdc_pkg::DATA_W-1:0]      fill_value_i,

  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [tgdc_pkg::DATA_W-1:0]           tile_value_o,
  output logic [tgdc_pkg::OP_W-1:0]             finished_op_o,

  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [1:0]                       cfg_index_i,
  input  wire logic [tgdc_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int PIX_W  = tgdc_pkg::PIX_W;
  localparam int TILE_W = tgdc_pkg::TILE_W;
  localparam int TX_W   = tgdc_pkg::TX_W;
  localparam int DX_W   = tgdc_pkg::DX_W;
  localparam int R2_W   = tgdc_pkg::R2_W;
  localparam int D2_W   = tgdc_pkg::D2_W;
  localparam int RAD_W  = tgdc_pkg::RAD_W;
  localparam int CFG_W  = tgdc_pkg::CFG_W;
  localparam int CNT_W  = tgdc_pkg::CNT_W;
  localparam int IDX_W  = tgdc_pkg::IDX_W;
  localparam int LIM_W  = tgdc_pkg::LIM_W;
  localparam int COL_W  = tgdc_pkg::COL_W;
  localparam int ROW_W  = tgdc_pkg::ROW_W;
  localparam int ADDR_W = tgdc_pkg::ADDR_W;
  localparam int DATA_W = tgdc_pkg::DATA_W;
  localparam int OP_W   = tgdc_pkg::OP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_WALK,
    ST_FIN
  } state_e;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] tile_size_q, grid_width_q, grid_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q   <= tgdc_pkg::TILE_SIZE_RST;
      grid_width_q  <= tgdc_pkg::GRID_WIDTH_RST;
      grid_height_q <= tgdc_pkg::GRID_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tgdc_pkg::CFG_TILE_SIZE:   tile_size_q   <= cfg_data_i;
        tgdc_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        tgdc_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] ts_eff;
  logic [LIM_W-1:0] used_cols, used_rows;

  assign ts_eff    = (tile_size_q == '0) ? CFG_W'(1) : tile_size_q;
  assign used_cols = tgdc_pkg::used_dim(grid_width_q, LIM_W'(tgdc_pkg::MAX_COLS));
  assign used_rows = tgdc_pkg::used_dim(grid_height_q, LIM_W'(tgdc_pkg::MAX_ROWS));

  // --------------------------------------------------------------------------
  // sequencer registers
  // --------------------------------------------------------------------------
  state_e                  state_q;
  logic [OP_W-1:0]         res_op_q;
  logic [DATA_W-1:0]       rd_data_q;
  logic [DATA_W-1:0]       fill_q;
  logic [RAD_W-1:0]        r_q;
  logic [R2_W-1:0]         r2_q;
  logic signed [DX_W-1:0]  dx_q, dy_q;
  logic signed [D2_W-1:0]  d2_q, dy2_q;
  logic signed [PIX_W-1:0] px_q, py_q, xs_px_q;
  logic [TX_W-1:0]         tx_q, ty_q, xs_tile_q;
  logic [CFG_W-1:0]        rx_q, ry_q, xs_rem_q;
  logic [TILE_W-1:0]       div_n_q;
  logic [CFG_W-1:0]        div_r_q;
  logic [CNT_W-1:0]        div_cnt_q;
  logic                    out_valid_q;
  logic [DATA_W-1:0]       tile_value_q;
  logic [OP_W-1:0]         finished_op_q;

  logic in_xfer;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // carve set-up values from the input
  logic [RAD_W-1:0]        rad_sat;
  logic signed [PIX_W-1:0] px0, py0;

  assign rad_sat = (int'(radius_i) > tgdc_pkg::MAX_RADIUS) ?
                   RAD_W'(tgdc_pkg::MAX_RADIUS) : RAD_W'(radius_i);
  assign px0 = $signed({coord_x_i[tgdc_pkg::COORD_W-1], coord_x_i}) -
               $signed({{(PIX_W-RAD_W){1'b0}}, rad_sat});
  assign py0 = $signed({coord_y_i[tgdc_pkg::COORD_W-1], coord_y_i}) -
               $signed({{(PIX_W-RAD_W){1'b0}}, rad_sat});

  // direct read / write address
  logic [IDX_W-1:0]  io_col, io_row;
  logic [ADDR_W-1:0] io_addr;

  assign io_col  = tgdc_pkg::clamp_idx($signed({coord_x_i[tgdc_pkg::COORD_W-1], coord_x_i}),
                                       used_cols);
  assign io_row  = tgdc_pkg::clamp_idx($signed({coord_y_i[tgdc_pkg::COORD_W-1], coord_y_i}),
                                       used_rows);
  assign io_addr = tgdc_pkg::tile_addr(io_row[ROW_W-1:0], io_col[COL_W-1:0]);

  // --------------------------------------------------------------------------
  // shared restoring divider step: one quotient bit a cycle
  // --------------------------------------------------------------------------
  logic [CFG_W:0]    div_sh;
  logic              div_ge;
  logic [CFG_W-1:0]  div_r_nx;
  logic [TILE_W-1:0] div_n_nx;
  logic              div_last;

  always_comb begin
    div_sh   = {div_r_q, div_n_q[TILE_W-1]};
    div_ge   = (div_sh >= {1'b0, ts_eff});
    div_r_nx = div_ge ? CFG_W'(div_sh - {1'b0, ts_eff}) : div_sh[CFG_W-1:0];
    div_n_nx = {div_n_q[TILE_W-2:0], div_ge};
    div_last = (div_cnt_q == CNT_W'(TILE_W - 1));
  end

  // --------------------------------------------------------------------------
  // pixel stepper: next tile column and row without division
  // --------------------------------------------------------------------------
  logic signed [PIX_W-1:0] npx, npy;
  logic [TX_W-1:0]         ntx, nty;
  logic [CFG_W-1:0]        nrx, nry;
  logic signed [D2_W-1:0]  d2_x, dy2_n, d2_row;
  logic signed [DX_W-1:0]  r_s;
  logic                    in_disc, row_end, walk_end;

  always_comb begin
    npx = px_q + PIX_W'(1);
    npy = py_q + PIX_W'(1);
    // a pixel at or left of zero lies in tile zero
    if (npx <= 0) begin
      ntx = '0;
      nrx = '0;
    end else if (rx_q == ts_eff - CFG_W'(1)) begin
      ntx = tx_q + TX_W'(1);
      nrx = '0;
    end else begin
      ntx = tx_q;
      nrx = rx_q + CFG_W'(1);
    end
    if (npy <= 0) begin
      nty = '0;
      nry = '0;
    end else if (ry_q == ts_eff - CFG_W'(1)) begin
      nty = ty_q + TX_W'(1);
      nry = '0;
    end else begin
      nty = ty_q;
      nry = ry_q + CFG_W'(1);
    end
    // (d+1)^2 = d^2 + 2d + 1
    d2_x   = d2_q + $signed({{(D2_W-DX_W-1){dx_q[DX_W-1]}}, dx_q, 1'b1});
    dy2_n  = dy2_q + $signed({{(D2_W-DX_W-1){dy_q[DX_W-1]}}, dy_q, 1'b1});
    d2_row = dy2_n + $signed({{(D2_W-R2_W){1'b0}}, r2_q});
    r_s      = $signed({{(DX_W-RAD_W){1'b0}}, r_q});
    in_disc  = (d2_q <= $signed({{(D2_W-R2_W){1'b0}}, r2_q}));
    row_end  = (dx_q == r_s);
    walk_end = row_end && (dy_q == r_s);
  end

  logic [IDX_W-1:0]  walk_col, walk_row;
  logic [ADDR_W-1:0] walk_addr;

  assign walk_col  = tgdc_pkg::clamp_idx($signed({1'b0, tx_q}), used_cols);
  assign walk_row  = tgdc_pkg::clamp_idx($signed({1'b0, ty_q}), used_rows);
  assign walk_addr = tgdc_pkg::tile_addr(walk_row[ROW_W-1:0], walk_col[COL_W-1:0]);

  // --------------------------------------------------------------------------
  // tile store: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] mem_q [tgdc_pkg::DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              rd_en;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = io_addr;
    mem_wdata = fill_value_i;
    if (state_q == ST_WALK) begin
      mem_we    = in_disc;
      mem_waddr = walk_addr;
      mem_wdata = fill_q;
    end else if (in_xfer && (operation_i == tgdc_pkg::OP_WRITE)) begin
      mem_we = 1'b1;
    end
  end

  assign rd_en = in_xfer && (operation_i == tgdc_pkg::OP_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[io_addr];
    end
  end

  // --------------------------------------------------------------------------
  // sequencer and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      res_op_q      <= tgdc_pkg::OP_READ;
      fill_q        <= '0;
      r_q           <= '0;
      r2_q          <= '0;
      dx_q          <= '0;
      dy_q          <= '0;
      d2_q          <= '0;
      dy2_q         <= '0;
      px_q          <= '0;
      py_q          <= '0;
      xs_px_q       <= '0;
      tx_q          <= '0;
      ty_q          <= '0;
      xs_tile_q     <= '0;
      rx_q          <= '0;
      ry_q          <= '0;
      xs_rem_q      <= '0;
      div_n_q       <= '0;
      div_r_q       <= '0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      tile_value_q  <= '0;
      finished_op_q <= tgdc_pkg::OP_READ;
    end else begin
      // in the final state a leaving result is replaced by the new one
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            res_op_q <= operation_i;
            fill_q   <= fill_value_i;
            r_q      <= rad_sat;
            r2_q     <= R2_W'(rad_sat) * R2_W'(rad_sat);
            px_q     <= px0;
            xs_px_q  <= px0;
            py_q     <= py0;
            // a start pixel at or left of zero divides as zero
            div_n_q   <= px0[PIX_W-1] ? '0 : px0[TILE_W-1:0];
            div_r_q   <= '0;
            div_cnt_q <= '0;
            case (operation_i)
              tgdc_pkg::OP_READ,
              tgdc_pkg::OP_WRITE: state_q <= ST_FIN;
              tgdc_pkg::OP_CARVE: state_q <= ST_DIV_X;
              default:            state_q <= ST_IDLE;
            endcase
          end
        end
        ST_DIV_X: begin
          div_n_q   <= div_n_nx;
          div_r_q   <= div_r_nx;
          div_cnt_q <= div_cnt_q + CNT_W'(1);
          if (div_last) begin
            tx_q      <= TX_W'(div_n_nx);
            rx_q      <= div_r_nx;
            xs_tile_q <= TX_W'(div_n_nx);
            xs_rem_q  <= div_r_nx;
            div_n_q   <= py_q[PIX_W-1] ? '0 : py_q[TILE_W-1:0];
            div_r_q   <= '0;
            div_cnt_q <= '0;
            state_q   <= ST_DIV_Y;
          end
        end
        ST_DIV_Y: begin
          div_n_q   <= div_n_nx;
          div_r_q   <= div_r_nx;
          div_cnt_q <= div_cnt_q + CNT_W'(1);
          if (div_last) begin
            ty_q    <= TX_W'(div_n_nx);
            ry_q    <= div_r_nx;
            dx_q    <= -r_s;
            dy_q    <= -r_s;
            dy2_q   <= $signed({{(D2_W-R2_W){1'b0}}, r2_q});
            d2_q    <= $signed({{(D2_W-R2_W-1){1'b0}}, r2_q, 1'b0});
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_end) begin
            state_q <= ST_FIN;
          end else if (row_end) begin
            dx_q  <= -r_s;
            dy_q  <= dy_q + DX_W'(1);
            dy2_q <= dy2_n;
            d2_q  <= d2_row;
            px_q  <= xs_px_q;
            tx_q  <= xs_tile_q;
            rx_q  <= xs_rem_q;
            py_q  <= npy;
            ty_q  <= nty;
            ry_q  <= nry;
          end else begin
            dx_q <= dx_q + DX_W'(1);
            d2_q <= d2_x;
            px_q <= npx;
            tx_q <= ntx;
            rx_q <= nrx;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            finished_op_q <= res_op_q;
            tile_value_q  <= (res_op_q == tgdc_pkg::OP_READ) ? rd_data_q : '0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tile_value_o  = tile_value_q;
  assign finished_op_o = finished_op_q;

`ifndef SYNTHESIS
  // incremental squared distance matches the offsets
  a_dist_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |->
      (int'(d2_q) == int'(dx_q) * int'(dx_q) + int'(dy_q) * int'(dy_q)))
    else $error("squared distance out of step with offsets");

  // divider and stepper remainders stay below the tile size
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV_X) || (state_q == ST_DIV_Y) || (state_q == ST_WALK)) |->
      (div_r_q < ts_eff) &&
      ((state_q != ST_WALK) || ((rx_q < ts_eff) && (ry_q < ts_eff))))
    else $error("remainder reached tile size");

  // store writes land inside the used grid
  a_wr_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (LIM_W'(mem_waddr / tgdc_pkg::MAX_COLS) < used_rows) &&
               (LIM_W'(mem_waddr % tgdc_pkg::MAX_COLS) < used_cols))
    else $error("tile write outside used grid");

  // an ignored operation never yields a result
  a_no_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (finished_op_o != tgdc_pkg::OP_NONE))
    else $error("result for ignored operation");
`endif

endmodule
`default_nettype wire

### tb/sv/tile_grid_disc_carver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_grid_disc_carver_test
// Drives read, write and disc carve operations into the tile grid under a
// range of tile sizes and grid sizes, predicts each result from a private
// copy of the tile store, and checks every result transfer in order. Reads
// only ever target tiles that an earlier operation has already written.
// ----------------------------------------------------------------------------
module tile_grid_disc_carver_test;

  localparam int OP_W       = tgdc_pkg::OP_W;
  localparam int COORD_W    = tgdc_pkg::COORD_W;
  localparam int DATA_W     = tgdc_pkg::DATA_W;
  localparam int CFG_W      = tgdc_pkg::CFG_W;
  localparam int DEPTH      = tgdc_pkg::DEPTH;
  localparam int MAX_COLS   = tgdc_pkg::MAX_COLS;
  localparam int MAX_ROWS   = tgdc_pkg::MAX_ROWS;
  localparam int MAX_RADIUS = tgdc_pkg::MAX_RADIUS;

  localparam int STUCK_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 190;
  localparam int PHASES       = 8;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [5:0]                radius;
    logic [DATA_W-1:0]         fill;
  } tile_op_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [OP_W-1:0]   op;
  } tile_result_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_stall_o;
  logic [OP_W-1:0]           operation_i   = tgdc_pkg::OP_READ;
  logic signed [COORD_W-1:0] coord_x_i     = '0;
  logic signed [COORD_W-1:0] coord_y_i     = '0;
  logic [5:0]                radius_i      = '0;
  logic [DATA_W-1:0]         fill_value_i  = '0;
  logic                      out_valid_o;
  logic                      out_stall_i   = 1'b0;
  logic [DATA_W-1:0]         tile_value_o;
  logic [OP_W-1:0]           finished_op_o;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [1:0]                cfg_index_i   = tgdc_pkg::CFG_TILE_SIZE;
  logic [CFG_W-1:0]          cfg_data_i    = '0;

  tile_grid_disc_carver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .radius_i      (radius_i),
    .fill_value_i  (fill_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tile_value_o  (tile_value_o),
    .finished_op_o (finished_op_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow of the tile store and registers
  logic [DATA_W-1:0] tile_model [DEPTH];
  bit                tile_known [DEPTH];
  int                ts_reg = tgdc_pkg::TILE_SIZE_RST;
  int                gw_reg = tgdc_pkg::GRID_WIDTH_RST;
  int                gh_reg = tgdc_pkg::GRID_HEIGHT_RST;

  tile_op_t     op_queue[$];
  tile_result_t pending_results[$];
  tile_op_t     driven_op;

  int mismatch_count = 0;
  int idle_rate      = 10;
  bit quiet          = 1'b0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int stall_left     = 0;
  int gap_left       = 0;
  int stuck_cycles   = 0;
  bit have_last_write = 1'b0;
  int last_wx, last_wy;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int used_span(int g, int maxv);
    if (g == 0) return 1;
    if (g > maxv) return maxv;
    return g;
  endfunction

  function automatic int clamp_coord(int v, int lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  // floor division; anything negative lands on tile 0 after clamping
  function automatic int pixel_tile(int p);
    int ts;
    ts = (ts_reg == 0) ? 1 : ts_reg;
    return (p < 0) ? -1 : p / ts;
  endfunction

  function automatic int tile_slot(int tx, int ty);
    return clamp_coord(ty, used_span(gh_reg, MAX_ROWS)) * MAX_COLS
         + clamp_coord(tx, used_span(gw_reg, MAX_COLS));
  endfunction

  task automatic mark_tile(int slot, logic [DATA_W-1:0] v);
    tile_model[slot] = v;
    tile_known[slot] = 1'b1;
  endtask

  task automatic apply_tile_op(input tile_op_t t);
    tile_result_t res;
    int           rad;
    int           cx;
    int           cy;
    res.value = '0;
    res.op    = t.op;
    cx        = int'(t.x);
    cy        = int'(t.y);
    case (t.op)
      tgdc_pkg::OP_READ: begin
        res.value = tile_model[tile_slot(cx, cy)];
      end
      tgdc_pkg::OP_WRITE: begin
        mark_tile(tile_slot(cx, cy), t.fill);
      end
      tgdc_pkg::OP_CARVE: begin
        rad = (int'(t.radius) > MAX_RADIUS) ? MAX_RADIUS : int'(t.radius);
        for (int dy = -rad; dy <= rad; dy++) begin
          for (int dx = -rad; dx <= rad; dx++) begin
            if (dx * dx + dy * dy <= rad * rad) begin
              mark_tile(tile_slot(pixel_tile(cx + dx), pixel_tile(cy + dy)), t.fill);
            end
          end
        end
      end
      default: ;
    endcase
    if (t.op != tgdc_pkg::OP_NONE) pending_results.push_back(res);
  endtask

  task automatic flag_mismatch(string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // sender: one operation per transfer, random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_tile_op(driven_op);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!quiet && idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
          gap_left = $urandom_range(1, 14) - 1;
          in_valid_i <= 1'b0;
        end else if (op_queue.size() > 0) begin
          driven_op = op_queue.pop_front();
          operation_i  <= driven_op.op;
          coord_x_i    <= driven_op.x;
          coord_y_i    <= driven_op.y;
          radius_i     <= driven_op.radius;
          fill_value_i <= driven_op.fill;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer, stalls in bursts or long holds
  always @(posedge clk_i or negedge rst_ni) begin
    tile_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result op %0d value %0h with nothing pending",
                                  finished_op_o, tile_value_o));
        end else begin
          want = pending_results.pop_front();
          if (tile_value_o !== want.value)
            flag_mismatch($sformatf("tile_value %0h, predicted %0h", tile_value_o, want.value));
          if (finished_op_o !== want.op)
            flag_mismatch($sformatf("finished_op %0d, predicted %0d", finished_op_o, want.op));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic queue_op(logic [OP_W-1:0] op, int x, int y, int rad, int fill);
    tile_op_t t;
    while (op_queue.size() >= 4) @(negedge clk_i);
    t.op     = op;
    t.x      = COORD_W'(x);
    t.y      = COORD_W'(y);
    t.radius = 6'(rad);
    t.fill   = DATA_W'(fill);
    op_queue.push_back(t);
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 16383)) - 8192;
  endfunction

  function automatic int rand_cfg_value();
    if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 127));
    return int'($urandom_range(1, 64));
  endfunction

  task automatic wait_idle();
    while (op_queue.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tgdc_pkg::CFG_TILE_SIZE:   ts_reg = val;
      tgdc_pkg::CFG_GRID_WIDTH:  gw_reg = val;
      tgdc_pkg::CFG_GRID_HEIGHT: gh_reg = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(int ts, int gw, int gh);
    wait_idle();
    // let the block settle before the configuration changes
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_cfg(tgdc_pkg::CFG_TILE_SIZE, ts);
    write_cfg(tgdc_pkg::CFG_GRID_WIDTH, gw);
    write_cfg(tgdc_pkg::CFG_GRID_HEIGHT, gh);
    have_last_write = 1'b0;
  endtask

  task automatic queue_random_op(output bit counted);
    int  sel;
    int  cols;
    int  rows;
    int  ts;
    int  r;
    int  x;
    int  y;
    int  col;
    int  row;
    bit  found;
    cols    = used_span(gw_reg, MAX_COLS);
    rows    = used_span(gh_reg, MAX_ROWS);
    ts      = (ts_reg == 0) ? 1 : ts_reg;
    sel     = $urandom_range(0, 99);
    counted = 1'b1;
    if (sel < 3) begin
      queue_op(tgdc_pkg::OP_NONE, rand_coord(), rand_coord(), $urandom_range(0, 63),
               $urandom_range(0, 255));
      counted = 1'b0;
    end else if (sel < 38) begin
      if ($urandom_range(0, 6) == 0) begin
        x = rand_coord();
        y = rand_coord();
      end else begin
        x = $urandom_range(0, cols - 1);
        y = $urandom_range(0, rows - 1);
      end
      queue_op(tgdc_pkg::OP_WRITE, x, y, $urandom_range(0, 63), $urandom_range(0, 255));
      last_wx = x;
      last_wy = y;
      have_last_write = 1'b1;
    end else if (sel < 75) begin
      // reads only hit tiles already written by an earlier transfer
      found = 1'b0;
      if (have_last_write && $urandom_range(0, 2) == 0) begin
        x = last_wx;
        y = last_wy;
        found = 1'b1;
      end
      for (int k = 0; k < 32 && !found; k++) begin
        col = $urandom_range(0, cols - 1);
        row = $urandom_range(0, rows - 1);
        if (tile_known[row * MAX_COLS + col]) begin
          found = 1'b1;
          x = col;
          y = row;
          if (col == 0 && $urandom_range(0, 3) == 0) x = -int'($urandom_range(1, 8192));
          if (col == cols - 1 && $urandom_range(0, 3) == 0)
            x = int'($urandom_range(cols, 8191));
          if (row == 0 && $urandom_range(0, 3) == 0) y = -int'($urandom_range(1, 8192));
          if (row == rows - 1 && $urandom_range(0, 3) == 0)
            y = int'($urandom_range(rows, 8191));
        end
      end
      if (found) begin
        queue_op(tgdc_pkg::OP_READ, x, y, $urandom_range(0, 63), $urandom_range(0, 255));
      end else begin
        queue_op(tgdc_pkg::OP_WRITE, $urandom_range(0, cols - 1),
                 $urandom_range(0, rows - 1), $urandom_range(0, 63),
                 $urandom_range(0, 255));
      end
    end else begin
      // mostly small discs, a few wide ones
      sel = $urandom_range(0, 99);
      if (sel < 90) r = $urandom_range(0, 6);
      else if (sel < 97) r = $urandom_range(7, 20);
      else r = $urandom_range(21, 63);
      if ($urandom_range(0, 7) == 0) begin
        x = rand_coord();
        y = rand_coord();
      end else begin
        x = int'($urandom_range(0, cols * ts + 2 * r)) - r;
        y = int'($urandom_range(0, rows * ts + 2 * r)) - r;
      end
      queue_op(tgdc_pkg::OP_CARVE, x, y, r, $urandom_range(0, 255));
    end
  endtask

  initial begin
    int phase_ts   [PHASES];
    int phase_gw   [PHASES];
    int phase_gh   [PHASES];
    int phase_rate [PHASES];
    int n;
    bit counted;
    phase_ts   = '{1, 64, 0, 127, 3, 0, 0, 0};
    phase_gw   = '{64, 1, 0, 127, 17, 0, 0, 0};
    phase_gh   = '{64, 1, 0, 127, 40, 0, 0, 0};
    phase_rate = '{10, 30, 0, 15, 5, 40, 0, 20};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset geometry: 10 pixel tiles, 50 x 30 grid
    queue_op(tgdc_pkg::OP_WRITE, -8192, -8192, 0, 8'hFF);
    queue_op(tgdc_pkg::OP_WRITE, 8191, 8191, 0, 8'h00);
    queue_op(tgdc_pkg::OP_WRITE, 5, 7, 63, 8'hA5);
    queue_op(tgdc_pkg::OP_READ, -1, -8192, 0, 0);
    queue_op(tgdc_pkg::OP_READ, 8191, 8191, 63, 8'hFF);
    queue_op(tgdc_pkg::OP_READ, 5, 7, 0, 0);
    queue_op(tgdc_pkg::OP_CARVE, 55, 75, 0, 8'h3C);
    queue_op(tgdc_pkg::OP_READ, 5, 7, 0, 0);
    queue_op(tgdc_pkg::OP_CARVE, -8192, -8192, 63, 8'h5A);
    queue_op(tgdc_pkg::OP_READ, 0, 0, 0, 0);
    queue_op(tgdc_pkg::OP_CARVE, 8191, 8191, 63, 8'hC3);
    queue_op(tgdc_pkg::OP_READ, 49, 8191, 0, 0);
    queue_op(tgdc_pkg::OP_CARVE, 250, 150, 12, 8'h81);
    queue_op(tgdc_pkg::OP_READ, 25, 15, 0, 0);
    queue_op(tgdc_pkg::OP_CARVE, 3, 3, 5, 8'h7E);
    queue_op(tgdc_pkg::OP_READ, 0, 0, 0, 0);
    queue_op(tgdc_pkg::OP_NONE, -8192, 8191, 63, 8'hFF);
    queue_op(tgdc_pkg::OP_WRITE, -8192, 8191, 0, 8'h01);
    queue_op(tgdc_pkg::OP_READ, 0, 100, 0, 0);
    queue_op(tgdc_pkg::OP_WRITE, 8191, -8192, 21, 8'h55);
    queue_op(tgdc_pkg::OP_READ, 60, -1, 42, 8'hAA);

    for (int p = 0; p < PHASES; p++) begin
      if (phase_ts[p] == 0 && p >= 5) begin
        phase_ts[p] = rand_cfg_value();
        phase_gw[p] = rand_cfg_value();
        phase_gh[p] = rand_cfg_value();
      end
      set_grid(phase_ts[p], phase_gw[p], phase_gh[p]);
      idle_rate = phase_rate[p];
      n = 0;
      while (n < PHASE_ITEMS) begin
        queue_random_op(counted);
        if (counted) begin
          n++;
          // long receiver hold while the sender keeps offering
          if (p == 0 && n == 60) hold_requests++;
          // sender pause until everything in flight has come back
          if (p == 2 && n == 100) wait_idle();
          if (p == PHASES - 1 && n == PHASE_ITEMS - 150) quiet = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/tgdc_pkg.sv
rtl/tile_grid_disc_carver.sv
tb/sv/tile_grid_disc_carver_test.sv
